FILE: sv/motor_pwm_timing_setup_defines.svh
// ------------------------------------------------------------------------
// motor_pwm_timing_setup_defines
// Assertion macros used by the top RTL file of the PWM timing setup block.
// ------------------------------------------------------------------------
`ifndef MOTOR_PWM_TIMING_SETUP_DEFINES_SVH
`define MOTOR_PWM_TIMING_SETUP_DEFINES_SVH

// same-cycle implication, ignored while reset is asserted
`define MPTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while reset is asserted
`define MPTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mpts_pkg.sv
// ------------------------------------------------------------------------
// mpts_pkg
// Types, constants and helpers of the motor PWM timing setup block.
// ------------------------------------------------------------------------
package mpts_pkg;

    localparam int unsigned CLOCK_HZ_DEF     = 120000000;
    localparam int unsigned PERIOD_LIMIT_DEF = 65536;

    localparam logic [23:0] MAX_FREQ_HZ = 24'd12000000;
    localparam logic [10:0] DUTY_FULL   = 11'd2000;
    localparam logic [1:0]  MAX_DIV_STEPS = 2'd3;

    // ceil(2^30 / 125); floor(x * CMP_RECIP / 2^30) == floor(x / 125)
    // for every x below 2^23, so duty*cycles/2000 = ((p >> 4) * CMP_RECIP) >> 30
    localparam logic [23:0] CMP_RECIP = 24'd8589935;

    // shared divider widths
    localparam int unsigned DVD_W = 32;
    localparam int unsigned DVS_W = 24;

    // command codes
    localparam logic [1:0] FUNC_FREQ   = 2'd0;
    localparam logic [1:0] FUNC_DUTY   = 2'd1;
    localparam logic [1:0] FUNC_SELECT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PHASE_A = 2'd0;
    localparam logic [1:0] REG_PHASE_B = 2'd1;
    localparam logic [1:0] REG_PHASE_C = 2'd2;

    // phase codes
    localparam logic [1:0] PHASE_NONE = 2'd0;
    localparam logic [1:0] PHASE_A    = 2'd1;
    localparam logic [1:0] PHASE_B    = 2'd2;
    localparam logic [1:0] PHASE_C    = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // 16^steps - 1
    function automatic logic [11:0] presc_of(input logic [1:0] steps);
        logic [11:0] r;
        case (steps)
            2'd0:    r = 12'd0;
            2'd1:    r = 12'd15;
            2'd2:    r = 12'd255;
            default: r = 12'd4095;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/mpts_divider.sv
// ------------------------------------------------------------------------
// mpts_divider
// Iterative restoring divider, one quotient bit per cycle.
// ------------------------------------------------------------------------
module mpts_divider
    import mpts_pkg::*;
#(
    parameter int unsigned W_DVD = DVD_W,
    parameter int unsigned W_DVS = DVS_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W_DVD-1:0] i_dividend,
    input  logic [W_DVS-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [W_DVD-1:0] o_quotient
);

    localparam int unsigned CNT_W = $clog2(W_DVD);

    logic [W_DVS-1:0] r_rem;
    logic [W_DVD-1:0] r_quo;
    logic [W_DVS-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W_DVS:0]   trial;
    logic [W_DVS:0]   diff;
    logic             qbit;

    always_comb begin
        trial = {r_rem, r_quo[W_DVD-1]};
        diff  = trial - {1'b0, r_dvs};
        qbit  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W_DVD - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[W_DVS-1:0] : trial[W_DVS-1:0];
            r_quo <= {r_quo[W_DVD-2:0], qbit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

FILE: sv/motor_pwm_timing_setup.sv
// ------------------------------------------------------------------------
// motor_pwm_timing_setup
// Three-phase motor PWM timing setup: prescaler, period and compare.
// ------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = func (set frequency, set duty, select pin),
//   tdata = value. One request gives exactly one result on the master
//   stream: prescaler, period, compare, active phase and error flag.
//   Pin registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata;
//   the user must do so only while the block is idle (not enforced).
// Sequence:
//   Select pin, unused codes, out-of-range frequency: the request goes
//   straight to the output step. Set duty: multiply, reciprocal
//   multiply for the division by 2000, output.
//   Set frequency: division of the clock by the frequency in the
//   divider, 1 to 4 scaling checks, both compare multiplies, output;
//   a zero cycle count is rejected as soon as the division is done.
//   o_s_tready is low while a request is in work, so a new request is
//   taken only once the last result loads; it rises as that result loads.
// Reset: synchronous, active low; restores period count 7500 at prescaler
//   15, duty 0, no phase selected and pins A=0, B=1, C=2.
// Stall: the result waits in the output register; the next request is
//   taken meanwhile and its result waits until the register frees up.
// ------------------------------------------------------------------------
`include "motor_pwm_timing_setup_defines.svh"

module motor_pwm_timing_setup
    import mpts_pkg::*;
#(
    parameter int unsigned CLOCK_HZ     = CLOCK_HZ_DEF,
    parameter int unsigned PERIOD_LIMIT = PERIOD_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [23:0] value
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [11:0] prescaler, [27:12] period, [43:28] compare,
    // [45:44] active_phase, [46] error, [47] zero
    output logic [47:0] o_m_tdata
);

    localparam logic [DVD_W-1:0] CLK_DVD   = DVD_W'(CLOCK_HZ);
    localparam logic [DVD_W-1:0] CYC_MAX   = DVD_W'(PERIOD_LIMIT - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FDIV  = 3'd1;
    localparam logic [2:0] S_SCALE = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_CDIV  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]       r_state;
    logic [7:0]       r_pin_a, r_pin_b, r_pin_c;
    logic [10:0]      r_duty;
    logic [15:0]      r_cycle;
    logic [11:0]      r_presc;
    logic [15:0]      r_compare;
    logic [1:0]       r_phase;
    logic             r_err;
    logic [DVD_W-1:0] r_q;       // cycle count being scaled
    logic [1:0]       r_steps;
    logic [26:0]      r_prod;
    logic             r_out_valid;
    logic [46:0]      r_out;

    t_div_stat        div_stat;
    logic [DVD_W-1:0] div_quo;
    logic             s_accept;
    logic             out_free;
    logic [1:0]       n_phase;
    logic [23:0]      value;
    logic             freq_bad;
    logic             fdiv_go;
    logic [45:0]      cmp_full;

    assign value    = i_s_tdata;
    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // zero or above 12 MHz is rejected before any division
    assign freq_bad = (value == 24'd0) || (value > MAX_FREQ_HZ);
    assign fdiv_go  = s_accept && (i_s_tuser == FUNC_FREQ) && !freq_bad;

    // duty*cycles/2000: drop the factor 16 exactly, then 1/125 by reciprocal
    assign cmp_full = 46'(r_prod[26:4]) * 46'(CMP_RECIP);

    // divider is loaded straight from the accepted request
    mpts_divider #(
        .W_DVD (DVD_W),
        .W_DVS (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (fdiv_go),
        .i_dividend (CLK_DVD),
        .i_divisor  (value),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // pin match, A wins over B, B over C
    always_comb begin
        if (value == {16'd0, r_pin_a})
            n_phase = PHASE_A;
        else if (value == {16'd0, r_pin_b})
            n_phase = PHASE_B;
        else if (value == {16'd0, r_pin_c})
            n_phase = PHASE_C;
        else
            n_phase = PHASE_NONE;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_a <= 8'd0;
            r_pin_b <= 8'd1;
            r_pin_c <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PHASE_A: r_pin_a <= i_cfg_wdata;
                REG_PHASE_B: r_pin_b <= i_cfg_wdata;
                REG_PHASE_C: r_pin_c <= i_cfg_wdata;
                default:     ;
            endcase
        end
    end

    // sequencer and timing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_duty      <= 11'd0;
            r_cycle     <= 16'd7500;
            r_presc     <= 12'd15;
            r_compare   <= 16'd0;
            r_phase     <= PHASE_NONE;
            r_err       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        case (i_s_tuser)
                            FUNC_FREQ: begin
                                if (freq_bad) begin
                                    r_err   <= 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_err   <= 1'b0;
                                    r_state <= S_FDIV;
                                end
                            end
                            FUNC_DUTY: begin
                                r_err   <= 1'b0;
                                r_duty  <= (value > {13'd0, DUTY_FULL}) ?
                                           DUTY_FULL : value[10:0];
                                r_state <= S_MUL;
                            end
                            FUNC_SELECT: begin
                                r_err   <= 1'b0;
                                r_phase <= n_phase;
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_err   <= 1'b0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_FDIV: begin
                    if (div_stat.done) begin
                        r_q     <= div_quo;
                        r_steps <= 2'd0;
                        if (div_quo == '0) begin
                            // clock slower than the request
                            r_err   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCALE;
                        end
                    end
                end
                S_SCALE: begin
                    // one divide-by-16 step per cycle
                    if (r_q > CYC_MAX) begin
                        if (r_steps == MAX_DIV_STEPS) begin
                            r_err   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_q     <= r_q >> 4;
                            r_steps <= r_steps + 2'd1;
                        end
                    end else begin
                        r_cycle <= r_q[15:0];
                        r_presc <= presc_of(r_steps);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 27'(r_duty * r_cycle);
                    r_state <= S_CDIV;
                end
                S_CDIV: begin
                    r_compare <= cmp_full[45:30];
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out   <= {r_err, r_phase, r_compare,
                                    r_cycle - 16'd1, r_presc};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register valid: loaded from the output step, freed by the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out};

    `MPTS_ASSERT_NOW(a_div_done_state, div_stat.done, r_state == S_FDIV,
        "divider done outside the divide state")
    `MPTS_ASSERT_NOW(a_div_idle, r_state == S_IDLE, !div_stat.busy,
        "divider busy while the sequencer is idle")
    `MPTS_ASSERT_NOW(a_duty_range, 1'b1, r_duty <= DUTY_FULL, "duty above full scale")
    `MPTS_ASSERT_NEXT(a_accept_busy, s_accept, r_state != S_IDLE,
        "request accepted but sequencer stayed idle")
    `MPTS_ASSERT_NOW(a_out_from_seq, $rose(o_m_tvalid), $past(r_state) == S_OUT,
        "result raised outside the output step")

endmodule
